@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the UTF-8 decoder modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define CHK_PROP(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define CHK_NEVER(lbl, clk_s, rst_s, expr, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(expr)) else $error(msg);
`else
`define CHK_PROP(lbl, clk_s, rst_s, prop, msg)
`define CHK_NEVER(lbl, clk_s, rst_s, expr, msg)
`endif

`endif

@@ design/u8dec_pkg.sv @@
// ----------------------------------------------------------------------------
// u8dec_pkg
// Types, constants and helpers shared by the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8dec_pkg;

  localparam int CP_W            = 21;
  localparam int MAX_RES         = 4;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] ESC_HIGH   = 8'hDC;  // escape base 0xDC00, upper byte
  localparam logic [7:0] LEAD_MIN   = 8'hC2;
  localparam logic [7:0] LEAD_LIMIT = 8'hF5;
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] LEAD_F0    = 8'hF0;
  localparam logic [7:0] LEAD_F4    = 8'hF4;
  localparam logic [7:0] CONT_A0    = 8'hA0;
  localparam logic [7:0] CONT_90    = 8'h90;
  localparam logic [7:0] ASCII_LIM  = 8'h80;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            escaped;
  } u8dec_res_t;

  // One classified request: up to four results, delivered in slot order.
  typedef struct packed {
    logic [2:0]                num;
    u8dec_res_t [MAX_RES-1:0]  res;
  } u8dec_job_t;

  function automatic u8dec_res_t escape_res(input logic [7:0] b);
    u8dec_res_t r;
    r.code_point = {5'b0, ESC_HIGH, b};
    r.escaped    = 1'b1;
    return r;
  endfunction

endpackage

@@ design/u8dec_front.sv @@
// ----------------------------------------------------------------------------
// u8dec_front
// Accepts bytes, tracks the pending sequence and classifies each request
// into a job of zero to four results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8dec_front
  import u8dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_stream,
  input  logic        q_full,
  output logic        push,
  output u8dec_job_t  job
);

  logic [7:0] pending_bytes [3];
  logic [1:0] pending_count;
  logic [1:0] pending_count_next;

  logic       accept;
  logic [7:0] lead;
  logic       ok;
  logic [2:0] need;
  logic [2:0] cnt_plus;
  logic       complete;
  logic [1:0] flush_n;
  logic       has_tail;
  u8dec_res_t tail;
  logic       wr_en;
  logic [1:0] wr_idx;
  logic [CP_W-1:0] cp_seq;

  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;

  always_comb begin
    lead     = pending_bytes[0];
    cnt_plus = {1'b0, pending_count} + 3'd1;
    ok       = (in_byte[7:6] == 2'b10);
    if (pending_count == 2'd1) begin
      if (lead == LEAD_E0 && in_byte < CONT_A0) ok = 1'b0;
      if (lead == LEAD_F0 && in_byte < CONT_90) ok = 1'b0;
      if (lead == LEAD_F4 && in_byte >= CONT_90) ok = 1'b0;
    end
    if (lead < LEAD_E0) begin
      need   = 3'd2;
      cp_seq = {10'b0, lead[4:0], in_byte[5:0]};
    end else if (lead < LEAD_F0) begin
      need   = 3'd3;
      cp_seq = {5'b0, lead[3:0], pending_bytes[1][5:0], in_byte[5:0]};
    end else begin
      need   = 3'd4;
      cp_seq = {lead[2:0], pending_bytes[1][5:0], pending_bytes[2][5:0], in_byte[5:0]};
    end
    complete = ok && (cnt_plus == need);

    flush_n            = 2'd0;
    has_tail           = 1'b0;
    tail.code_point    = cp_seq;
    tail.escaped       = 1'b0;
    wr_en              = 1'b0;
    wr_idx             = 2'd0;
    pending_count_next = pending_count;

    if (end_of_stream) begin
      flush_n            = pending_count;
      pending_count_next = 2'd0;
    end else if (pending_count != 2'd0 && ok) begin
      if (complete) begin
        has_tail           = 1'b1;
        pending_count_next = 2'd0;
      end else begin
        wr_en              = 1'b1;
        wr_idx             = pending_count;
        pending_count_next = cnt_plus[1:0];
      end
    end else begin
      // With nothing pending, or a broken sequence flushed, the byte starts afresh.
      flush_n = pending_count;
      if (in_byte < ASCII_LIM) begin
        has_tail           = 1'b1;
        tail.code_point    = {13'b0, in_byte};
        pending_count_next = 2'd0;
      end else if (in_byte < LEAD_MIN || in_byte >= LEAD_LIMIT) begin
        has_tail           = 1'b1;
        tail               = escape_res(in_byte);
        pending_count_next = 2'd0;
      end else begin
        wr_en              = 1'b1;
        wr_idx             = 2'd0;
        pending_count_next = 2'd1;
      end
    end

    for (int j = 0; j < 3; j++) begin
      job.res[j] = (2'(j) < flush_n) ? escape_res(pending_bytes[j]) : tail;
    end
    job.res[3] = tail;
    job.num    = {1'b0, flush_n} + {2'b0, has_tail};
  end

  assign push = accept && (job.num != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= 2'd0;
    end else if (accept) begin
      pending_count <= pending_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      pending_bytes[wr_idx] <= in_byte;
    end
  end

  `CHK_PROP(a_eos_empties, clk, rst, accept && end_of_stream |=> pending_count == 2'd0, "end of stream left bytes pending")
  `CHK_NEVER(a_job_size, clk, rst, push && job.num > 3'd4, "job holds more than four results")

endmodule

@@ design/u8dec_queue.sv @@
// ----------------------------------------------------------------------------
// u8dec_queue
// Short FIFO of classified jobs between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8dec_queue
  import u8dec_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH_DEF
)(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  u8dec_job_t wr_job,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output u8dec_job_t head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

  u8dec_job_t       slots [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full      = (count == CntW'(Depth));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LastIdx) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LastIdx) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  `CHK_NEVER(a_no_overflow, clk, rst, push && full, "push into a full job queue")
  `CHK_NEVER(a_no_underflow, clk, rst, pop && !not_empty, "pop from an empty job queue")

endmodule

@@ design/u8dec_back.sv @@
// ----------------------------------------------------------------------------
// u8dec_back
// Walks the head job one result per cycle while result_ready is high and drives the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8dec_back
  import u8dec_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  u8dec_job_t      head,
  output logic            pop,
  output logic            result_valid,
  input  logic            result_ready,
  output logic [CP_W-1:0] code_point,
  output logic            escaped,
  output logic            last
);

  logic [1:0] idx;
  logic [1:0] idx_next;
  logic       taken;

  assign result_valid = q_valid;
  assign code_point   = head.res[idx].code_point;
  assign escaped      = head.res[idx].escaped;
  assign last         = ({1'b0, idx} + 3'd1 == head.num);
  assign taken        = result_valid && result_ready;
  assign pop          = taken && last;

  always_comb begin
    idx_next = idx;
    if (taken) idx_next = last ? 2'd0 : idx + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else begin
      idx <= idx_next;
    end
  end

  `CHK_NEVER(a_idx_in_job, clk, rst, q_valid && ({1'b0, idx} >= head.num), "result index beyond job")

endmodule

@@ design/utf8_stream_decoder_escape.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder_escape
// UTF-8 byte stream decoder that escapes invalid bytes as 0xDC00 plus byte.
// ----------------------------------------------------------------------------
// The job of a request is registered in the job queue and its first result
//   is offered once the job reaches the queue head. Throughput: one byte per
//   cycle while the queue is not full and each byte yields at most one result;
//   the back part delivers one result per cycle while result_ready is high.
// Reset (synchronous, rst high) empties the pending sequence, the job queue
//   and the result index; held bytes themselves are not cleared.
`timescale 1ns / 1ps

module utf8_stream_decoder_escape
  import u8dec_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH_DEF
)(
  input  logic            clk,
  input  logic            rst,
  // Byte channel: one request per accepted byte or end-of-stream marker.
  input  logic            byte_valid,
  output logic            byte_ready,
  input  logic [7:0]      in_byte,
  input  logic            end_of_stream,
  // Result channel: code points or escapes, last marks a request's final one.
  output logic            result_valid,
  input  logic            result_ready,
  output logic [CP_W-1:0] code_point,
  output logic            escaped,
  output logic            last
);

  // The front part owns the pending-sequence state and turns every request
  // into a job: the escapes of any flushed bytes, in order, followed by at
  // most one decoded code point or escape. Requests that only extend a
  // pending sequence produce no job and never touch the queue.
  u8dec_job_t job;
  u8dec_job_t head;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_not_empty;

  u8dec_front u_front (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_ready    (byte_ready),
    .in_byte       (in_byte),
    .end_of_stream (end_of_stream),
    .q_full        (q_full),
    .push          (push),
    .job           (job)
  );

  // The queue decouples the two sides, so a stalled result port does not
  // stop bytes from being taken until the queue has filled.
  u8dec_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_job    (job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  // The back part steps through the head job's results and releases the
  // job once its last result has been taken.
  u8dec_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_not_empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .code_point   (code_point),
    .escaped      (escaped),
    .last         (last)
  );

endmodule

@@ tb/utf8_stream_decoder_escape_tb.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder_escape_tb
// Self-checking bench for the UTF-8 stream decoder. Byte requests are sent in
// random bursts and every result is checked against a behavioural decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_stream_decoder_escape_tb
  import u8dec_pkg::*;
();

  localparam int unsigned RANDOM_BYTES = 300;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;

  // One decoded character as it should appear on the result port.
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            escaped;
    logic            last;
  } char_result_t;

  // Shapes of byte groups in the random stream.
  typedef enum int unsigned {
    KIND_WELL_FORMED,
    KIND_BROKEN,
    KIND_LONE_BYTE,
    KIND_FLUSH,
    KIND_STRAY_CONT
  } group_kind_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            byte_valid = 1'b0;
  logic            byte_ready;
  logic [7:0]      in_byte = 8'h00;
  logic            end_of_stream = 1'b0;
  logic            result_valid;
  logic            result_ready = 1'b0;
  logic [CP_W-1:0] code_point;
  logic            escaped;
  logic            last;

  // Characters predicted but not yet seen on the result port, oldest first.
  char_result_t expected_chars[$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;

  // Behavioural copy of the decoder state: bytes of an unfinished sequence.
  logic [7:0]   held_bytes[3];
  int unsigned  held_count = 0;

  // Sender burst bookkeeping.
  int unsigned  burst_left = 0;

  // Receiver stall pattern state.
  int unsigned  stall_mode = 0;
  int unsigned  stall_left = 0;
  int unsigned  stall_phase = 0;

  utf8_stream_decoder_escape u_top (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .in_byte      (in_byte),
    .end_of_stream(end_of_stream),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .code_point   (code_point),
    .escaped      (escaped),
    .last         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop, in case the decoder hangs or loses a result.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Behavioural decoder
  // --------------------------------------------------------------------------

  function automatic void push_char(input logic [CP_W-1:0] cp, input logic esc);
    char_result_t r;
    r.code_point = cp;
    r.escaped    = esc;
    r.last       = 1'b0;
    expected_chars.push_back(r);
  endfunction

  // Every held byte becomes an escape, in arrival order, and the sequence is
  // abandoned.
  function automatic void flush_held();
    for (int unsigned i = 0; i < held_count; i++)
      push_char({5'b0, ESC_HIGH, held_bytes[i]}, 1'b1);
    held_count = 0;
  endfunction

  // Works out the characters that one accepted request produces and queues
  // them, marking the final one of the request.
  function automatic void predict_decode(input logic [7:0] b, input logic eos);
    int unsigned first_idx;
    int unsigned need;
    int unsigned cp;
    logic [7:0]  lead;
    logic        ok;
    logic        fresh;
    first_idx = expected_chars.size();
    fresh     = !eos;
    if (eos) begin
      flush_held();
    end else if (held_count > 0) begin
      lead = held_bytes[0];
      ok   = (b[7:6] == 2'b10);
      // The second byte also rules out overlong forms and values past the
      // top of the code space.
      if (held_count == 1) begin
        if (lead == LEAD_E0 && b < CONT_A0) ok = 1'b0;
        if (lead == LEAD_F0 && b < CONT_90) ok = 1'b0;
        if (lead == LEAD_F4 && b >= CONT_90) ok = 1'b0;
      end
      if (ok) begin
        fresh = 1'b0;
        need  = (lead < LEAD_E0) ? 2 : (lead < LEAD_F0) ? 3 : 4;
        if (held_count + 1 == need) begin
          if (need == 2)
            cp = (int'(lead) << 6) + int'(b) - 32'h3080;
          else if (need == 3)
            cp = (int'(lead) << 12) + (int'(held_bytes[1]) << 6) + int'(b) - 32'hE2080;
          else
            cp = (int'(lead) << 18) + (int'(held_bytes[1]) << 12)
                 + (int'(held_bytes[2]) << 6) + int'(b) - 32'h3C82080;
          held_count = 0;
          push_char(cp[CP_W-1:0], 1'b0);
        end else begin
          held_bytes[held_count] = b;
          held_count++;
        end
      end else begin
        flush_held();
      end
    end
    // A byte with nothing held, or one that broke a sequence, starts afresh.
    if (fresh) begin
      if (b < ASCII_LIM) begin
        push_char({13'b0, b}, 1'b0);
      end else if (b < LEAD_MIN || b >= LEAD_LIMIT) begin
        push_char({5'b0, ESC_HIGH, b}, 1'b1);
      end else begin
        held_bytes[0] = b;
        held_count    = 1;
      end
    end
    if (expected_chars.size() > first_idx)
      expected_chars[expected_chars.size() - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Byte sender
  // --------------------------------------------------------------------------

  // Sends one request. Requests go out in bursts; between bursts valid is
  // dropped for a random number of cycles, sometimes none at all.
  task automatic send_request(input logic [7:0] b, input logic eos);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        byte_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    byte_valid    <= 1'b1;
    in_byte       <= b;
    end_of_stream <= eos;
    do @(posedge clk); while (!byte_ready);
    predict_decode(b, eos);
  endtask

  // --------------------------------------------------------------------------
  // Result receiver: ready follows one of several patterns, each held for a
  // random stretch, so that stalls land on every position of a multi-result
  // request and some stretches run with no stall at all.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 80);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0: result_ready <= 1'b1;
      1: result_ready <= ($urandom_range(0, 99) < 70);
      2: result_ready <= (stall_phase % 5 != 0);
      default: result_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    char_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected result: code_point %h escaped %b last %b",
               code_point, escaped, last);
        error_count++;
      end else begin
        want = expected_chars.pop_front();
        if (code_point !== want.code_point) begin
          $error("code_point: expected %h, got %h", want.code_point, code_point);
          error_count++;
        end
        if (escaped !== want.escaped) begin
          $error("escaped: expected %b, got %b", want.escaped, escaped);
          error_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %b, got %b", want.last, last);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // ASCII extremes and bytes that can never start a sequence.
  task automatic test_single_bytes();
    send_request(8'h00, 1'b0);
    send_request(8'h7F, 1'b0);
    send_request(8'h80, 1'b0);
    send_request(8'hC1, 1'b0);
    send_request(8'hF5, 1'b0);
    send_request(8'hFF, 1'b0);
  endtask

  // Complete sequences: the smallest two-byte value, a surrogate, which is
  // passed through, and the top of the code space.
  task automatic test_valid_sequences();
    send_request(8'hC2, 1'b0);
    send_request(8'h80, 1'b0);
    send_request(8'hED, 1'b0);
    send_request(8'hA0, 1'b0);
    send_request(8'h80, 1'b0);
    send_request(8'hF4, 1'b0);
    send_request(8'h8F, 1'b0);
    send_request(8'hBF, 1'b0);
    send_request(8'hBF, 1'b0);
  endtask

  // Overlong three- and four-byte forms, a value above the top of the code
  // space and a plain bad continuation.
  task automatic test_broken_sequences();
    send_request(8'hE0, 1'b0);
    send_request(8'h9F, 1'b0);
    send_request(8'hF0, 1'b0);
    send_request(8'h8F, 1'b0);
    send_request(8'hF4, 1'b0);
    send_request(8'h90, 1'b0);
    send_request(8'hC2, 1'b0);
    send_request(8'h41, 1'b0);
  endtask

  // End of stream with nothing held, then with three bytes held.
  task automatic test_end_of_stream();
    send_request(8'hA5, 1'b1);
    send_request(8'hF1, 1'b0);
    send_request(8'h80, 1'b0);
    send_request(8'h80, 1'b0);
    send_request(8'h5A, 1'b1);
  endtask

  // Random stream built mostly from well-formed sequences with random
  // content, mixed with truncated and broken ones and plain noise.
  task automatic test_random_stream();
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    group_kind_t kind;
    logic [7:0]  lead;
    logic [7:0]  second;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      kind = (pick < 50) ? KIND_WELL_FORMED :
             (pick < 72) ? KIND_BROKEN :
             (pick < 87) ? KIND_LONE_BYTE :
             (pick < 95) ? KIND_FLUSH : KIND_STRAY_CONT;
      case (kind)
        KIND_WELL_FORMED: begin
          len = $urandom_range(1, 4);
          case (len)
            1: begin
              send_request(8'($urandom_range(8'h00, 8'h7F)), 1'b0);
            end
            2: begin
              send_request(8'($urandom_range(8'hC2, 8'hDF)), 1'b0);
              send_request(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
            end
            3: begin
              lead = 8'($urandom_range(8'hE0, 8'hEF));
              send_request(lead, 1'b0);
              send_request((lead == LEAD_E0) ? 8'($urandom_range(8'hA0, 8'hBF))
                                             : 8'($urandom_range(8'h80, 8'hBF)), 1'b0);
              send_request(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
            end
            default: begin
              lead = 8'($urandom_range(8'hF0, 8'hF4));
              second = (lead == LEAD_F0) ? 8'($urandom_range(8'h90, 8'hBF)) :
                       (lead == LEAD_F4) ? 8'($urandom_range(8'h80, 8'h8F)) :
                                           8'($urandom_range(8'h80, 8'hBF));
              send_request(lead, 1'b0);
              send_request(second, 1'b0);
              send_request(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
              send_request(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
            end
          endcase
          sent += len;
        end
        KIND_BROKEN: begin
          // A lead, up to two continuations, then any byte or an end of stream.
          send_request(8'($urandom_range(8'hC2, 8'hF4)), 1'b0);
          len = $urandom_range(0, 2);
          repeat (len) send_request(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
          if ($urandom_range(0, 3) == 0)
            send_request(8'($urandom_range(0, 255)), 1'b1);
          else
            send_request(8'($urandom_range(0, 255)), 1'b0);
          sent += len + 2;
        end
        KIND_LONE_BYTE: begin
          send_request(8'($urandom_range(0, 255)), 1'b0);
          sent++;
        end
        KIND_FLUSH: begin
          send_request(8'($urandom_range(0, 255)), 1'b1);
          sent++;
        end
        default: begin
          send_request(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
          sent++;
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_bytes();
    test_valid_sequences();
    test_broken_sequences();
    test_end_of_stream();
    test_random_stream();

    @(negedge clk);
    byte_valid <= 1'b0;

    // Wait for every predicted character, then let the decoder run on so that
    // any result that should not be there shows.
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
